// ===== hdl/rect_to_polar_convert_top_macros.svh =====
// assertion macros used by the rect to polar converter top
`ifndef RECT_TO_POLAR_CONVERT_TOP_MACROS_SVH
`define RECT_TO_POLAR_CONVERT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising edge, quiet while reset is asserted
`define R2P_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("r2p assertion failed");
`else
`define R2P_ASSERT(label, clk, rstn, prop)
`endif

`ifndef ASSERT_OFF
// implication checked in the same cycle
`define R2P_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("r2p assertion failed");
`else
`define R2P_ASSERT_IMP(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/r2p_pkg.sv =====
// types and constants of the rect to polar converter
`default_nettype none

package r2p_pkg;

  localparam int COORD_W        = 16;
  localparam int RAD_W          = 18;
  localparam int ANG_W          = 16;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 40;

  localparam int ITERATIONS_DEF = 16;
  localparam int MAX_ITER       = 24;
  localparam int SQRT_STEPS     = 18;

  localparam int ANG_FRAC       = 20;
  localparam int CW             = 38;  // cordic x/y datapath width
  localparam int ZW             = 24;  // angle accumulator width
  localparam int SQ_W           = 36;  // squared radius width

  localparam int PI_FINE        = 3294199;
  localparam int PI_Q13         = 25736;
  localparam int HALF_PI_Q13    = 12868;
  localparam int RAD_MAX        = 185364;

  // arctangent of 2^-i in units of 2^-20 rad
  localparam logic [22:0] ATAN_FINE [MAX_ITER] = '{
    23'd823550, 23'd486170, 23'd256879, 23'd130396, 23'd65451, 23'd32757,
    23'd16383,  23'd8192,   23'd4096,   23'd2048,   23'd1024,  23'd512,
    23'd256,    23'd128,    23'd64,     23'd32,     23'd16,    23'd8,
    23'd4,      23'd2,      23'd1,      23'd0,      23'd0,     23'd0
  };

  // one item moving down the cell row
  typedef struct packed {
    logic                 vld;
    logic                 y_zero;
    logic                 x_zero;
    logic                 x_neg;
    logic                 y_pos;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic [SQ_W-1:0]      rem;
    logic [SQ_W-1:0]      root;
  } r2p_data_t;

endpackage

`default_nettype wire

// ===== hdl/r2p_prep.sv =====
// input stages: squares, sum of squares and cordic start vector
`default_nettype none

module r2p_prep (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         vld_i,
  input  wire logic [r2p_pkg::COORD_W-1:0]  x_i,
  input  wire logic [r2p_pkg::COORD_W-1:0]  y_i,
  output r2p_pkg::r2p_data_t                d_o
);
  import r2p_pkg::*;

  // stage one
  logic                     vld1_r, vld1_nxt;
  logic [COORD_W-1:0]       x1_r, y1_r;
  logic [2*COORD_W-2:0]     xx1_r, yy1_r, xx1_nxt, yy1_nxt;
  logic signed [2*COORD_W-1:0] xp, yp;

  // stage two
  r2p_data_t                d2_r, d2_nxt;

  logic [2*COORD_W-1:0]     sum_sq;
  logic signed [COORD_W:0]  xa, ya;
  logic                     x_neg, y_pos;

  always_comb begin
    xp       = $signed(x_i) * $signed(x_i);
    yp       = $signed(y_i) * $signed(y_i);
    xx1_nxt  = xp[2*COORD_W-2:0];
    yy1_nxt  = yp[2*COORD_W-2:0];
    vld1_nxt = vld_i;
  end

  always_comb begin
    x_neg  = x1_r[COORD_W-1];
    y_pos  = !y1_r[COORD_W-1] && (y1_r != '0);
    sum_sq = {1'b0, xx1_r} + {1'b0, yy1_r};
    // left half plane: turn by pi first
    xa     = x_neg ? -$signed({x1_r[COORD_W-1], x1_r}) : $signed({x1_r[COORD_W-1], x1_r});
    ya     = x_neg ? -$signed({y1_r[COORD_W-1], y1_r}) : $signed({y1_r[COORD_W-1], y1_r});

    d2_nxt        = '0;
    d2_nxt.vld    = vld1_r;
    d2_nxt.y_zero = (y1_r == '0);
    d2_nxt.x_zero = (x1_r == '0);
    d2_nxt.x_neg  = x_neg;
    d2_nxt.y_pos  = y_pos;
    d2_nxt.cx     = CW'(xa) <<< ANG_FRAC;
    d2_nxt.cy     = CW'(ya) <<< ANG_FRAC;
    if (x_neg) begin
      d2_nxt.z = y_pos ? ZW'(PI_FINE) : -ZW'(PI_FINE);
    end else begin
      d2_nxt.z = '0;
    end
    d2_nxt.rem    = {sum_sq, 4'b0000};
    d2_nxt.root   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= x_i;
      y1_r  <= y_i;
      xx1_r <= xx1_nxt;
      yy1_r <= yy1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_r.vld <= 1'b0;
    end else if (en) begin
      d2_r.vld <= d2_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r.y_zero <= d2_nxt.y_zero;
      d2_r.x_zero <= d2_nxt.x_zero;
      d2_r.x_neg  <= d2_nxt.x_neg;
      d2_r.y_pos  <= d2_nxt.y_pos;
      d2_r.cx     <= d2_nxt.cx;
      d2_r.cy     <= d2_nxt.cy;
      d2_r.z      <= d2_nxt.z;
      d2_r.rem    <= d2_nxt.rem;
      d2_r.root   <= d2_nxt.root;
    end
  end

  assign d_o = d2_r;

endmodule

`default_nettype wire

// ===== hdl/r2p_cell.sv =====
// one cell: micro-rotation and/or root bit by index, then a register
`default_nettype none

module r2p_cell #(
  parameter int IDX        = 0,
  parameter int ITERATIONS = r2p_pkg::ITERATIONS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  r2p_pkg::r2p_data_t d_i,
  output r2p_pkg::r2p_data_t d_o
);
  import r2p_pkg::*;

  localparam int AIDX = (IDX < MAX_ITER) ? IDX : 0;
  localparam int K    = (IDX < SQRT_STEPS) ? (SQRT_STEPS - 1 - IDX) : 0;
  localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * K);

  r2p_data_t            d_r, d_nxt;
  logic signed [CW-1:0] cx_nxt, cy_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic [SQ_W-1:0]      rem_nxt, root_nxt;

  generate
    if (IDX < ITERATIONS) begin : g_rot
      logic signed [CW-1:0] cx_in, cy_in, dx, dy;
      logic signed [ZW-1:0] z_in, da;
      always_comb begin
        cx_in = d_i.cx;
        cy_in = d_i.cy;
        z_in  = d_i.z;
        dx    = cy_in >>> IDX;
        dy    = cx_in >>> IDX;
        da    = $signed(ZW'(ATAN_FINE[AIDX]));
        // residual y at or above zero rotates clockwise
        if (!cy_in[CW-1]) begin
          cx_nxt = cx_in + dx;
          cy_nxt = cy_in - dy;
          z_nxt  = z_in + da;
        end else begin
          cx_nxt = cx_in - dx;
          cy_nxt = cy_in + dy;
          z_nxt  = z_in - da;
        end
      end
    end else begin : g_rot_pass
      always_comb begin
        cx_nxt = d_i.cx;
        cy_nxt = d_i.cy;
        z_nxt  = d_i.z;
      end
    end

    if (IDX < SQRT_STEPS) begin : g_root
      logic [SQ_W:0] trial;
      always_comb begin
        trial = {1'b0, d_i.root} + {1'b0, SQ_BIT};
        if ({1'b0, d_i.rem} >= trial) begin
          rem_nxt  = d_i.rem - trial[SQ_W-1:0];
          root_nxt = (d_i.root >> 1) + SQ_BIT;
        end else begin
          rem_nxt  = d_i.rem;
          root_nxt = d_i.root >> 1;
        end
      end
    end else begin : g_root_pass
      always_comb begin
        rem_nxt  = d_i.rem;
        root_nxt = d_i.root;
      end
    end
  endgenerate

  always_comb begin
    d_nxt      = d_i;
    d_nxt.cx   = cx_nxt;
    d_nxt.cy   = cy_nxt;
    d_nxt.z    = z_nxt;
    d_nxt.rem  = rem_nxt;
    d_nxt.root = root_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.y_zero <= d_nxt.y_zero;
      d_r.x_zero <= d_nxt.x_zero;
      d_r.x_neg  <= d_nxt.x_neg;
      d_r.y_pos  <= d_nxt.y_pos;
      d_r.cx     <= d_nxt.cx;
      d_r.cy     <= d_nxt.cy;
      d_r.z      <= d_nxt.z;
      d_r.rem    <= d_nxt.rem;
      d_r.root   <= d_nxt.root;
    end
  end

  assign d_o = d_r;

endmodule

`default_nettype wire

// ===== hdl/r2p_final.sv =====
// output stage: radius rounding, angle rounding and clamp, axis cases
`default_nettype none

module r2p_final (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  r2p_pkg::r2p_data_t              d_i,
  output logic                            vld_o,
  output logic [r2p_pkg::RAD_W-1:0]       radius_o,
  output logic [r2p_pkg::ANG_W-1:0]       angle_o
);
  import r2p_pkg::*;

  logic                  vld_r, vld_nxt;
  logic [RAD_W-1:0]      radius_r, radius_nxt;
  logic [ANG_W-1:0]      angle_r, angle_nxt;
  logic signed [ZW:0]    z_rnd, q;

  always_comb begin
    vld_nxt    = d_i.vld;
    // halves round up
    radius_nxt = d_i.root[RAD_W-1:0] + RAD_W'(d_i.rem > d_i.root);

    z_rnd = $signed({d_i.z[ZW-1], d_i.z}) + $signed((ZW+1)'(64));
    q     = z_rnd >>> (ANG_FRAC - 13);
    if (q > $signed((ZW+1)'(PI_Q13))) begin
      q = $signed((ZW+1)'(PI_Q13));
    end else if (q < -$signed((ZW+1)'(PI_Q13))) begin
      q = -$signed((ZW+1)'(PI_Q13));
    end

    if (d_i.y_zero) begin
      angle_nxt = d_i.x_neg ? ANG_W'(PI_Q13) : '0;
    end else if (d_i.x_zero) begin
      angle_nxt = d_i.y_pos ? ANG_W'(HALF_PI_Q13) : -ANG_W'(HALF_PI_Q13);
    end else begin
      angle_nxt = q[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radius_r <= radius_nxt;
      angle_r  <= angle_nxt;
    end
  end

  assign vld_o    = vld_r;
  assign radius_o = radius_r;
  assign angle_o  = angle_r;

endmodule

`default_nettype wire

// ===== hdl/rect_to_polar_convert_top.sv =====
// top level of the rect to polar converter
`default_nettype none
`include "rect_to_polar_convert_top_macros.svh"

// rectangular to polar conversion, one point per clock while the output
// is read. each item carries a signed 16-bit x and y; the result gives the
// rounded magnitude in quarter units (18 bits unsigned) and the atan2 angle
// in signed q3.13 radians. the angle comes from a row of cordic cells, one
// micro-rotation per cell, and the magnitude from an exact restoring square
// root that resolves one root bit per cell in the same row; cells that have
// both jobs do them in lockstep. an item passes two input stages (squares,
// then their sum and the cordic start vector), the cell row, and the output
// register. a new item can be taken every cycle while the row advances; the
// whole row moves forward whenever the output register is empty or being
// read, so throughput is one item per cycle while the consumer keeps
// out_tready high. points on an axis bypass the cordic result: the origin
// and positive x with y of zero give angle 0, negative x with y of zero
// gives +pi, and x of zero gives +pi/2 or -pi/2 by the sign of y.
module rect_to_polar_convert_top #(
  parameter int ITERATIONS = r2p_pkg::ITERATIONS_DEF  // cordic micro-rotations, 8 to 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [r2p_pkg::IN_TDATA_W-1:0]    in_tdata,   // x_coord[15:0], y_coord[31:16]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [r2p_pkg::OUT_TDATA_W-1:0]        out_tdata   // radius[17:0], angle_rad[33:18], zero
);
  import r2p_pkg::*;

  localparam int NCELL = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;

  // pipeline advance: output empty or being taken
  logic             en;
  r2p_data_t        chain [NCELL+1];
  logic [RAD_W-1:0] radius;
  logic [ANG_W-1:0] angle;
  logic             angle_in_range;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  r2p_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_tvalid),
    .x_i   (in_tdata[COORD_W-1:0]),
    .y_i   (in_tdata[2*COORD_W-1:COORD_W]),
    .d_o   (chain[0])
  );

  // row of cells, each hands its item to the next every advancing cycle
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    r2p_cell #(
      .IDX        (i),
      .ITERATIONS (ITERATIONS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (chain[i]),
      .d_o   (chain[i+1])
    );
  end

  r2p_final u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .d_i      (chain[NCELL]),
    .vld_o    (out_tvalid),
    .radius_o (radius),
    .angle_o  (angle)
  );

  assign out_tdata = {(OUT_TDATA_W - RAD_W - ANG_W)'(0), angle, radius};

  // angle inside plus or minus pi
  assign angle_in_range = ($signed(angle) <= $signed(ANG_W'(PI_Q13))) &&
                          ($signed(angle) >= -$signed(ANG_W'(PI_Q13)));

  // an empty output register never blocks the input
  `R2P_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)
  // magnitude of a 16-bit point stays in range
  `R2P_ASSERT_IMP(a_radius_range, clk, rst_n, out_tvalid, radius <= RAD_W'(RAD_MAX))
  // angle after clamp stays within plus or minus pi
  `R2P_ASSERT_IMP(a_angle_range, clk, rst_n, out_tvalid, angle_in_range)

endmodule

`default_nettype wire
